[sv/cfq_pkg.sv]
// ----------------------------------------------------------------------------
// cfq_pkg: shared types and codes for the circular FIFO queue
// Command and status codes, the request and response items, and the control
// word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package cfq_pkg;

    // Command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_DUMP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } request_t;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } response_t;

    // Work handed to the back end
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_STATUS,
        OP_READ,
        OP_DUMP
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [1:0] status;
    } op_ctrl_t;

endpackage

[sv/cfq_front.sv]
// ----------------------------------------------------------------------------
// cfq_front: command decoder and pointer keeper
// Accepts commands, updates head, tail and empty flag at once, and posts one
// operation per known command to the operation queue; unused codes post none.
// ----------------------------------------------------------------------------
module cfq_front #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cfq_pkg::request_t request,
    output logic              full,
    input  logic              q_full,
    output logic              q_wr,
    output cfq_pkg::op_ctrl_t q_ctrl,
    output logic signed [31:0] q_value,
    output logic [AW-1:0]     q_addr_a,
    output logic [AW-1:0]     q_addr_b
);
    import cfq_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          is_empty_reg, is_empty_next;
    logic [AW-1:0] head_inc, tail_inc;
    logic          accept;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign q_value  = request.value;

    // Hold the pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            is_empty_reg <= 1'b1;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            is_empty_reg <= is_empty_next;
        end
    end

    // Decode the command, advance pointers, build the operation
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        is_empty_next = is_empty_reg;
        q_wr          = 1'b0;
        q_ctrl        = '{kind: OP_STATUS, status: ST_OK};
        q_addr_a      = head_reg;
        q_addr_b      = tail_reg;
        if (accept)
        begin
            unique case (request.command)
                CMD_PUSH:
                begin
                    q_wr = 1'b1;
                    if (is_empty_reg)
                    begin
                        head_next     = '0;
                        tail_next     = '0;
                        is_empty_next = 1'b0;
                        q_ctrl        = '{kind: OP_WRITE, status: ST_OK};
                        q_addr_a      = '0;
                    end
                    else if (tail_inc == head_reg)
                    begin
                        q_ctrl = '{kind: OP_STATUS, status: ST_FULL};
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        q_ctrl    = '{kind: OP_WRITE, status: ST_OK};
                        q_addr_a  = tail_inc;
                    end
                end
                CMD_POP:
                begin
                    q_wr = 1'b1;
                    if (is_empty_reg)
                    begin
                        q_ctrl = '{kind: OP_STATUS, status: ST_EMPTY};
                    end
                    else
                    begin
                        q_ctrl = '{kind: OP_READ, status: ST_OK};
                        if (head_reg == tail_reg)
                        begin
                            head_next     = '0;
                            tail_next     = '0;
                            is_empty_next = 1'b1;
                        end
                        else
                        begin
                            head_next = head_inc;
                        end
                    end
                end
                CMD_DUMP:
                begin
                    q_wr = 1'b1;
                    if (is_empty_reg)
                    begin
                        q_ctrl = '{kind: OP_STATUS, status: ST_EMPTY};
                    end
                    else
                    begin
                        q_ctrl = '{kind: OP_DUMP, status: ST_OK};
                    end
                end
                default:
                begin
                    // unused command code: drop the item
                    q_wr = 1'b0;
                end
            endcase
        end
    end

endmodule

[sv/cfq_op_queue.sv]
// ----------------------------------------------------------------------------
// cfq_op_queue: two-entry operation queue
// Decouples the command decoder from the storage back end so each side
// can stall on its own.
// ----------------------------------------------------------------------------
module cfq_op_queue #(
    parameter int AW = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  cfq_pkg::op_ctrl_t  wr_ctrl,
    input  logic signed [31:0] wr_value,
    input  logic [AW-1:0]      wr_addr_a,
    input  logic [AW-1:0]      wr_addr_b,
    output logic               full,
    output logic               rd_valid,
    output cfq_pkg::op_ctrl_t  rd_ctrl,
    output logic signed [31:0] rd_value,
    output logic [AW-1:0]      rd_addr_a,
    output logic [AW-1:0]      rd_addr_b,
    input  logic               rd_en
);
    import cfq_pkg::*;

    localparam int QD = 2;

    op_ctrl_t           ctrl_reg   [QD];
    logic signed [31:0] value_reg  [QD];
    logic [AW-1:0]      addr_a_reg [QD];
    logic [AW-1:0]      addr_b_reg [QD];
    logic               wp_reg, rp_reg;
    logic [1:0]         count_reg, count_next;
    logic               do_wr, do_rd;

    assign full      = (count_reg == 2'(QD));
    assign rd_valid  = (count_reg != 2'd0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && rd_valid;
    assign rd_ctrl   = ctrl_reg[rp_reg];
    assign rd_value  = value_reg[rp_reg];
    assign rd_addr_a = addr_a_reg[rp_reg];
    assign rd_addr_b = addr_b_reg[rp_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            ctrl_reg[wp_reg]   <= wr_ctrl;
            value_reg[wp_reg]  <= wr_value;
            addr_a_reg[wp_reg] <= wr_addr_a;
            addr_b_reg[wp_reg] <= wr_addr_b;
        end
    end

endmodule

[sv/cfq_back.sv]
// ----------------------------------------------------------------------------
// cfq_back: storage and result generator
// Owns the word memory, executes write, read, status and dump operations,
// and buffers results in a four-entry output queue.
// ----------------------------------------------------------------------------
module cfq_back #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  cfq_pkg::op_ctrl_t   op_ctrl,
    input  logic signed [31:0]  op_value,
    input  logic [AW-1:0]       op_addr_a,
    input  logic [AW-1:0]       op_addr_b,
    output logic                op_take,
    output logic                empty,
    input  logic                pop,
    output cfq_pkg::response_t  response
);
    import cfq_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam int            OQ       = 4;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    // Dump sequencer
    logic               dumping_reg, dumping_next;
    logic [AW-1:0]      dump_ptr_reg, dump_ptr_next;
    logic [AW-1:0]      cur_addr, cur_inc, rd_addr;

    // Result stage after the memory read
    logic               s1_valid_reg;
    logic [1:0]         s1_status_reg, s1_status_next;
    logic               s1_last_reg, s1_last_next;
    logic               s1_mem_reg, s1_mem_next;

    // Output queue
    response_t          oq_reg [OQ];
    logic [1:0]         owp_reg, orp_reg;
    logic [2:0]         ocount_reg, ocount_next;
    logic               issue, o_push, o_pop;
    response_t          o_item;

    assign cur_addr = dumping_reg ? dump_ptr_reg : op_addr_a;
    assign cur_inc  = (cur_addr == LAST_IDX) ? '0 : cur_addr + 1'b1;
    assign rd_addr  = (op_ctrl.kind == OP_DUMP) ? cur_addr : op_addr_a;
    assign issue    = op_valid && ((ocount_reg + {2'b00, s1_valid_reg}) < 3'(OQ));

    // Decide what the issued operation produces
    always_comb
    begin
        op_take        = 1'b0;
        dumping_next   = dumping_reg;
        dump_ptr_next  = dump_ptr_reg;
        s1_status_next = ST_OK;
        s1_last_next   = 1'b1;
        s1_mem_next    = 1'b0;
        if (issue)
        begin
            unique case (op_ctrl.kind)
                OP_WRITE:
                begin
                    op_take = 1'b1;
                end
                OP_STATUS:
                begin
                    op_take        = 1'b1;
                    s1_status_next = op_ctrl.status;
                end
                OP_READ:
                begin
                    op_take     = 1'b1;
                    s1_mem_next = 1'b1;
                end
                OP_DUMP:
                begin
                    s1_mem_next = 1'b1;
                    if (cur_addr == op_addr_b)
                    begin
                        op_take      = 1'b1;
                        dumping_next = 1'b0;
                    end
                    else
                    begin
                        s1_last_next  = 1'b0;
                        dumping_next  = 1'b1;
                        dump_ptr_next = cur_inc;
                    end
                end
                default:
                begin
                    op_take = 1'b1;
                end
            endcase
        end
    end

    // Write and read the word memory
    always_ff @(posedge clk)
    begin
        if (issue && op_ctrl.kind == OP_WRITE)
        begin
            mem[op_addr_a] <= op_value;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Hold result stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_status_reg <= s1_status_next;
            s1_last_reg   <= s1_last_next;
            s1_mem_reg    <= s1_mem_next;
        end
    end

    // Control registers of sequencer and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dumping_reg  <= 1'b0;
            dump_ptr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            dumping_reg  <= dumping_next;
            dump_ptr_reg <= dump_ptr_next;
            s1_valid_reg <= issue;
        end
    end

    // Form the result and queue it
    assign o_push      = s1_valid_reg;
    assign o_pop       = pop && !empty;
    assign empty       = (ocount_reg == 3'd0);
    assign response    = oq_reg[orp_reg];
    assign o_item.status = s1_status_reg;
    assign o_item.data   = s1_mem_reg ? rd_data_reg : 32'sd0;
    assign o_item.last   = s1_last_reg;

    always_comb
    begin
        ocount_next = ocount_reg;
        if (o_push && !o_pop)
        begin
            ocount_next = ocount_reg + 3'd1;
        end
        else if (o_pop && !o_push)
        begin
            ocount_next = ocount_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg    <= 2'd0;
            orp_reg    <= 2'd0;
            ocount_reg <= 3'd0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (o_push)
            begin
                owp_reg <= owp_reg + 2'd1;
            end
            if (o_pop)
            begin
                orp_reg <= orp_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_push)
        begin
            oq_reg[owp_reg] <= o_item;
        end
    end

endmodule

[sv/circular_fifo_queue.sv]
// ----------------------------------------------------------------------------
// circular_fifo_queue: command-driven circular FIFO of signed words
//
//   Channel    Handshake        Payload
//   request    push / full      request_t  (command, value)
//   response   empty / pop      response_t (status, data, last)
//
// Push and pop are single operations in the back end; a dump reads entries in
// turn through the single read port of the word memory. A result is registered
// in the operation queue, result stage and output queue. Reset is asynchronous
// and clears only pointers and flags; the word memory has no clearing pass.
// Stalls on pop back up through the output and operation queues to full.
// ----------------------------------------------------------------------------
module circular_fifo_queue #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cfq_pkg::request_t  request,
    output logic               empty,
    input  logic               pop,
    output cfq_pkg::response_t response
);
    import cfq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               wq_wr, wq_full;
    op_ctrl_t           wq_ctrl;
    logic signed [31:0] wq_value;
    logic [AW-1:0]      wq_addr_a, wq_addr_b;

    logic               rq_valid, rq_take;
    op_ctrl_t           rq_ctrl;
    logic signed [31:0] rq_value;
    logic [AW-1:0]      rq_addr_a, rq_addr_b;

    cfq_front #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .q_full   (wq_full),
        .q_wr     (wq_wr),
        .q_ctrl   (wq_ctrl),
        .q_value  (wq_value),
        .q_addr_a (wq_addr_a),
        .q_addr_b (wq_addr_b)
    );

    cfq_op_queue #(
        .AW (AW)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wq_wr),
        .wr_ctrl   (wq_ctrl),
        .wr_value  (wq_value),
        .wr_addr_a (wq_addr_a),
        .wr_addr_b (wq_addr_b),
        .full      (wq_full),
        .rd_valid  (rq_valid),
        .rd_ctrl   (rq_ctrl),
        .rd_value  (rq_value),
        .rd_addr_a (rq_addr_a),
        .rd_addr_b (rq_addr_b),
        .rd_en     (rq_take)
    );

    cfq_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (rq_valid),
        .op_ctrl   (rq_ctrl),
        .op_value  (rq_value),
        .op_addr_a (rq_addr_a),
        .op_addr_b (rq_addr_b),
        .op_take   (rq_take),
        .empty     (empty),
        .pop       (pop),
        .response  (response)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the circular FIFO queue
// Drives push, pop, dump and ignored commands through the request queue and
// drains the response queue with random idle cycles on both sides, apart from
// one steady stretch. A local model of the circular store predicts every
// response, and each is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import cfq_pkg::*;

    localparam int DEPTH = 8;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 12;

    // Command code that the block ignores
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic signed [31:0] MAX_WORD = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_WORD = 32'sh8000_0000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    request_t  request = '0;
    logic      empty;
    logic      pop = 1'b0;
    response_t response;

    // Local copy of the queue state
    logic signed [31:0] store_words [DEPTH];
    int                 head_slot;
    int                 tail_slot;
    bit                 store_empty;

    response_t pending_responses [$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        steady = 1'b0;

    circular_fifo_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .request(request),
        .empty(empty),
        .pop(pop),
        .response(response)
    );

    always #5 clk = ~clk;

    // Advance a slot index with wrap
    function automatic int next_slot(int i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    // Update the queue state for one command and queue the responses it causes
    function automatic void apply_command(request_t req);
        response_t rsp;
        int        i;
        bit        done;
        rsp = '0;
        rsp.last = 1'b1;
        case (req.command)
            CMD_PUSH:
            begin
                if (store_empty) begin
                    head_slot = 0;
                    tail_slot = 0;
                    store_empty = 1'b0;
                    store_words[0] = req.value;
                    rsp.status = ST_OK;
                end
                else if (next_slot(tail_slot) == head_slot) begin
                    rsp.status = ST_FULL;
                end
                else begin
                    tail_slot = next_slot(tail_slot);
                    store_words[tail_slot] = req.value;
                    rsp.status = ST_OK;
                end
                pending_responses.push_back(rsp);
            end
            CMD_POP:
            begin
                if (store_empty) begin
                    rsp.status = ST_EMPTY;
                end
                else begin
                    rsp.status = ST_OK;
                    rsp.data = store_words[head_slot];
                    if (head_slot == tail_slot) begin
                        store_empty = 1'b1;
                        head_slot = 0;
                        tail_slot = 0;
                    end
                    else begin
                        head_slot = next_slot(head_slot);
                    end
                end
                pending_responses.push_back(rsp);
            end
            CMD_DUMP:
            begin
                if (store_empty) begin
                    rsp.status = ST_EMPTY;
                    pending_responses.push_back(rsp);
                end
                else begin
                    // Walk from head to tail, oldest first
                    i = head_slot;
                    done = 1'b0;
                    while (!done) begin
                        done = (i == tail_slot);
                        rsp.status = ST_OK;
                        rsp.data = store_words[i];
                        rsp.last = done;
                        pending_responses.push_back(rsp);
                        i = next_slot(i);
                    end
                end
            end
            default:
            begin
                // Ignored command: no response, no state change
            end
        endcase
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(logic [1:0] cmd, logic signed [31:0] val);
        int       gap;
        request_t req;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.command = cmd;
        req.value = val;
        push <= 1'b1;
        request <= req;
        @(negedge clk);
        while (full) @(negedge clk);
        @(posedge clk);
        apply_command(req);
    endtask

    // Empty queue: pop, dump and the ignored command
    task automatic test_empty_queue();
        send_item(CMD_POP, MAX_WORD);
        send_item(CMD_DUMP, MIN_WORD);
        send_item(CMD_NONE, -32'sd1);
        send_item(CMD_POP, 32'sd0);
    endtask

    // Fill to capacity, overflow, dump a full queue, then drain past empty
    task automatic test_fill_and_drain();
        logic signed [31:0] words [4];
        words = '{MAX_WORD, MIN_WORD, 32'sd0, -32'sd1};
        for (int k = 0; k < DEPTH; k++)
            send_item(CMD_PUSH, (k < 4) ? words[k] : $signed($urandom));
        send_item(CMD_PUSH, 32'sh5A5A_A5A5);
        send_item(CMD_DUMP, 32'sd0);
        for (int k = 0; k < DEPTH; k++)
            send_item(CMD_POP, $signed($urandom));
        send_item(CMD_POP, 32'sd0);
    endtask

    // Random commands in randomly chosen fill-leaning and drain-leaning stretches
    task automatic test_random_traffic(int item_count, bit no_idle);
        int                 sent;
        int                 roll;
        int                 push_share;
        logic [1:0]         cmd;
        logic signed [31:0] val;
        sent = 0;
        push_share = 55;
        steady = no_idle;
        while (sent < item_count) begin
            if (sent % 16 == 0)
                push_share = $urandom_range(0, 1) ? 60 : 25;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                cmd = CMD_NONE;
            else if (roll < 18)
                cmd = CMD_DUMP;
            else if (roll < 18 + push_share)
                cmd = CMD_PUSH;
            else
                cmd = CMD_POP;
            case ($urandom_range(0, 11))
                0:       val = MAX_WORD;
                1:       val = MIN_WORD;
                2:       val = 32'sd0;
                3:       val = -32'sd1;
                default: val = $signed($urandom);
            endcase
            send_item(cmd, val);
            if (cmd != CMD_NONE)
                sent++;
        end
        steady = 1'b0;
    endtask

    // Main sequence
    initial begin
        for (int k = 0; k < DEPTH; k++)
            store_words[k] = '0;
        head_slot = 0;
        tail_slot = 0;
        store_empty = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_and_drain();
        test_random_traffic(30, 1'b1);
        test_random_traffic(120, 1'b0);
        push <= 1'b0;

        // Wait for every predicted response, then let the pipeline settle
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("circular_fifo_queue: match");
        else
            $display("circular_fifo_queue: mismatch");
        $finish;
    end

    // Drain responses with random stalls and check each one
    initial begin : response_checker
        int        stall;
        response_t got;
        response_t want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
            while (empty) @(negedge clk);
            got = response;
            @(posedge clk);
            if (pending_responses.size() == 0) begin
                $error("unexpected response: status %0d data %0d last %0d",
                       got.status, got.data, got.last);
                error_count++;
            end
            else begin
                want = pending_responses.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.data !== want.data) begin
                    $error("data: expected %0d, got %0d", want.data, got.data);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Stop the run when nothing moves on either side for too long
    always @(negedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("circular_fifo_queue: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
